>>> hdl/rmlt_pkg.sv
// Package for the recursive monitor lock table.
// Holds field widths, command and status codes, and the controller-datapath
// structs. No dependencies.
`default_nettype none

package rmlt_pkg;

   // Fixed widths of the request and response fields.
   localparam int CMD_W       = 2;
   localparam int OBJECT_W    = 8;
   localparam int THREAD_W    = 4;
   localparam int STATUS_W    = 3;
   localparam int DEPTH_OUT_W = 16;
   localparam int WAIT_W      = 1 + OBJECT_W;

   // Request command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_QUERY        = 2'd0,
      CMD_ACQUIRE      = 2'd1,
      CMD_RELEASE      = 2'd2,
      CMD_PREPARE_WAIT = 2'd3
   } cmd_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_BUSY     = 3'd1,
      ST_NULL     = 3'd2,
      ST_ILLEGAL  = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sweep;
      logic capture;
      logic execute;
   } dp_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> hdl/rmlt_ctrl.sv
// Controller state machine for the recursive monitor lock table.
// Sequences the clearing pass and the read-then-update of each request.
// Depends on rmlt_pkg.
`default_nettype none

module rmlt_ctrl
   import rmlt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   output dp_ctrl_type      dp_ctrl,
   input  wire dp_stat_type dp_stat
);

   typedef enum logic [2:0] {
      S_SWEEP = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in        = state_ff;
      dp_ctrl.sweep   = 1'b0;
      dp_ctrl.capture = 1'b0;
      dp_ctrl.execute = 1'b0;
      case (state_ff)
         S_SWEEP: begin
            dp_ctrl.sweep = 1'b1;
            if (dp_stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               dp_ctrl.capture = 1'b1;
               state_in        = S_EXEC;
            end
         end
         S_EXEC: begin
            dp_ctrl.execute = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // An accepted request is executed in the following cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> dp_ctrl.execute)
      else $error("accepted request was not executed next cycle");

   // Execution lasts one cycle and leaves the block ready.
   a_exec_ready: assert property (@(posedge clock) disable iff (reset)
      dp_ctrl.execute |=> !busy)
      else $error("block still busy after execution");

   // The clearing pass happens only after reset.
   a_no_resweep: assert property (@(posedge clock) disable iff (reset)
      !dp_ctrl.sweep |=> !dp_ctrl.sweep)
      else $error("clearing pass re-entered without reset");

endmodule

`default_nettype wire

>>> hdl/rmlt_datapath.sv
// Datapath for the recursive monitor lock table: request registers, lock and
// wait memories, the update logic and the response registers.
// Depends on rmlt_pkg.
`default_nettype none

module rmlt_datapath
   import rmlt_pkg::*;
#(
   parameter int NUM_OBJECTS = 256,
   parameter int NUM_THREADS = 16,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dp_ctrl_type            dp_ctrl,
   output dp_stat_type                 dp_stat,
   input  wire logic [CMD_W-1:0]       req_cmd,
   input  wire logic [OBJECT_W-1:0]    req_object_index,
   input  wire logic [THREAD_W-1:0]    req_thread_index,
   input  wire logic                   req_object_live,
   output logic                        rsp_strobe,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic                        rsp_is_locked,
   output logic [THREAD_W-1:0]         rsp_owner_thread,
   output logic                        rsp_caller_owns,
   output logic [DEPTH_OUT_W-1:0]      rsp_hold_depth,
   output logic                        rsp_wait_valid,
   output logic [OBJECT_W-1:0]         rsp_wait_object
);

   localparam int OBJ_AW    = $clog2(NUM_OBJECTS);
   localparam int THR_AW    = $clog2(NUM_THREADS);
   localparam int SWEEP_LEN = (NUM_OBJECTS > NUM_THREADS) ? NUM_OBJECTS : NUM_THREADS;
   localparam int SWP_W     = $clog2(SWEEP_LEN);
   localparam int LOCK_W    = 1 + THREAD_W + COUNT_BITS;

   // Request registers.
   cmd_type               cmd_ff;
   logic [OBJECT_W-1:0]   obj_ff;
   logic [THREAD_W-1:0]   thr_ff;
   logic                  live_ff;

   // Memories and their registered read data.
   logic [LOCK_W-1:0]     lock_mem [NUM_OBJECTS];
   logic [WAIT_W-1:0]     wait_mem [NUM_THREADS];
   logic [LOCK_W-1:0]     lock_rd_ff;
   logic [WAIT_W-1:0]     wait_rd_ff;

   // Clearing pass counter.
   logic [SWP_W-1:0]      sweep_cnt_ff;
   logic [SWP_W-1:0]      sweep_cnt_in;

   // Address forms of the request fields.
   logic [31:0]           req_obj_ext;
   logic [31:0]           req_thr_ext;
   logic [31:0]           obj_ext;
   logic [31:0]           thr_ext;
   logic [31:0]           sweep_ext;
   logic [OBJ_AW-1:0]     req_obj_addr;
   logic [THR_AW-1:0]     req_thr_addr;
   logic [OBJ_AW-1:0]     obj_addr;
   logic [THR_AW-1:0]     thr_addr;
   logic                  obj_ok;
   logic                  thr_ok;

   // Fields of the old entries.
   logic                  old_held;
   logic [THREAD_W-1:0]   old_owner;
   logic [COUNT_BITS-1:0] old_depth;

   // Updated entries and write controls.
   logic                  new_held;
   logic [THREAD_W-1:0]   new_owner;
   logic [COUNT_BITS-1:0] new_depth;
   logic [WAIT_W-1:0]     new_wait;
   logic                  lock_upd;
   logic                  wait_upd;
   status_type            status;

   logic                  lock_we;
   logic [OBJ_AW-1:0]     lock_waddr;
   logic [LOCK_W-1:0]     lock_wdata;
   logic                  wait_we;
   logic [THR_AW-1:0]     wait_waddr;
   logic [WAIT_W-1:0]     wait_wdata;

   // Response registers.
   logic                  rsp_strobe_ff;
   status_type            rsp_status_ff;
   logic                  rsp_is_locked_ff;
   logic [THREAD_W-1:0]   rsp_owner_ff;
   logic                  rsp_owns_ff;
   logic [DEPTH_OUT_W-1:0] rsp_depth_ff;
   logic                  rsp_wait_valid_ff;
   logic [OBJECT_W-1:0]   rsp_wait_obj_ff;
   logic [31:0]           new_depth_ext;

   // Address forms: widen, then take the bits the depth needs.
   assign req_obj_ext  = 32'(req_object_index);
   assign req_thr_ext  = 32'(req_thread_index);
   assign obj_ext      = 32'(obj_ff);
   assign thr_ext      = 32'(thr_ff);
   assign sweep_ext    = 32'(sweep_cnt_ff);
   assign req_obj_addr = req_obj_ext[OBJ_AW-1:0];
   assign req_thr_addr = req_thr_ext[THR_AW-1:0];
   assign obj_addr     = obj_ext[OBJ_AW-1:0];
   assign thr_addr     = thr_ext[THR_AW-1:0];
   assign obj_ok       = (obj_ext < 32'(NUM_OBJECTS));
   assign thr_ok       = (thr_ext < 32'(NUM_THREADS));

   // Request registers load when a request is accepted.
   always_ff @(posedge clock) begin
      if (dp_ctrl.capture) begin
         cmd_ff  <= cmd_type'(req_cmd);
         obj_ff  <= req_object_index;
         thr_ff  <= req_thread_index;
         live_ff <= req_object_live;
      end
   end

   // Clearing pass counter walks every entry of both memories once.
   assign sweep_cnt_in       = sweep_cnt_ff + SWP_W'(1);
   assign dp_stat.sweep_last = (sweep_cnt_ff == SWP_W'(SWEEP_LEN - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else if (dp_ctrl.sweep) begin
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   // Split the old lock entry.
   assign old_held  = lock_rd_ff[LOCK_W-1];
   assign old_owner = lock_rd_ff[COUNT_BITS +: THREAD_W];
   assign old_depth = lock_rd_ff[COUNT_BITS-1:0];

   // Lock and wait update for one request.
   always_comb begin
      new_held  = old_held;
      new_owner = old_owner;
      new_depth = old_depth;
      new_wait  = wait_rd_ff;
      lock_upd  = 1'b0;
      wait_upd  = 1'b0;
      status    = ST_OK;
      if (!obj_ok || !live_ff) begin
         status = ST_NULL;
      end else if (!thr_ok) begin
         status = ST_ILLEGAL;
      end else begin
         case (cmd_ff)
            CMD_ACQUIRE: begin
               if (!old_held || (old_owner == thr_ff)) begin
                  if (old_depth == {COUNT_BITS{1'b1}}) begin
                     status = ST_OVERFLOW;
                  end else begin
                     new_held  = 1'b1;
                     new_owner = thr_ff;
                     new_depth = old_depth + COUNT_BITS'(1);
                     new_wait  = '0;
                     lock_upd  = 1'b1;
                     wait_upd  = 1'b1;
                  end
               end else begin
                  new_wait = {1'b1, obj_ff};
                  wait_upd = 1'b1;
                  status   = ST_BUSY;
               end
            end
            CMD_RELEASE: begin
               if (old_held && (old_owner == thr_ff)) begin
                  lock_upd = 1'b1;
                  if (old_depth <= COUNT_BITS'(1)) begin
                     new_held  = 1'b0;
                     new_owner = '0;
                     new_depth = '0;
                  end else begin
                     new_depth = old_depth - COUNT_BITS'(1);
                  end
               end else begin
                  status = ST_ILLEGAL;
               end
            end
            CMD_PREPARE_WAIT: begin
               new_wait = {1'b1, obj_ff};
               wait_upd = 1'b1;
            end
            default: begin
               status = ST_OK;
            end
         endcase
      end
   end

   // Write port selection: clearing pass or request update.
   assign lock_we    = (dp_ctrl.sweep && (sweep_ext < 32'(NUM_OBJECTS)))
                       || (dp_ctrl.execute && lock_upd);
   assign lock_waddr = dp_ctrl.sweep ? sweep_cnt_ff[OBJ_AW-1:0] : obj_addr;
   assign lock_wdata = dp_ctrl.sweep ? '0 : {new_held, new_owner, new_depth};
   assign wait_we    = (dp_ctrl.sweep && (sweep_ext < 32'(NUM_THREADS)))
                       || (dp_ctrl.execute && wait_upd);
   assign wait_waddr = dp_ctrl.sweep ? sweep_cnt_ff[THR_AW-1:0] : thr_addr;
   assign wait_wdata = dp_ctrl.sweep ? '0 : new_wait;

   // Lock memory: one write, one registered read at acceptance.
   always_ff @(posedge clock) begin
      if (lock_we) begin
         lock_mem[lock_waddr] <= lock_wdata;
      end
      if (dp_ctrl.capture) begin
         lock_rd_ff <= lock_mem[req_obj_addr];
      end
   end

   // Wait memory: one write, one registered read at acceptance.
   always_ff @(posedge clock) begin
      if (wait_we) begin
         wait_mem[wait_waddr] <= wait_wdata;
      end
      if (dp_ctrl.capture) begin
         wait_rd_ff <= wait_mem[req_thr_addr];
      end
   end

   // Response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dp_ctrl.execute;
      end
   end

   assign new_depth_ext = 32'(new_depth);

   // Response payload reports the state after the update.
   always_ff @(posedge clock) begin
      if (dp_ctrl.execute) begin
         rsp_status_ff     <= status;
         rsp_is_locked_ff  <= obj_ok && new_held;
         rsp_owner_ff      <= obj_ok ? new_owner : '0;
         rsp_depth_ff      <= obj_ok ? new_depth_ext[DEPTH_OUT_W-1:0] : '0;
         rsp_owns_ff       <= obj_ok && thr_ok && new_held && (new_owner == thr_ff);
         rsp_wait_valid_ff <= thr_ok && new_wait[WAIT_W-1];
         rsp_wait_obj_ff   <= thr_ok ? new_wait[OBJECT_W-1:0] : '0;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_is_locked    = rsp_is_locked_ff;
   assign rsp_owner_thread = rsp_owner_ff;
   assign rsp_caller_owns  = rsp_owns_ff;
   assign rsp_hold_depth   = rsp_depth_ff;
   assign rsp_wait_valid   = rsp_wait_valid_ff;
   assign rsp_wait_object  = rsp_wait_obj_ff;

   // Every execution produces exactly one response strobe.
   a_exec_strobe: assert property (@(posedge clock) disable iff (reset)
      dp_ctrl.execute |=> rsp_strobe_ff)
      else $error("execution without response strobe");

   // A caller can only own a lock that is held.
   a_owns_locked: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_owns_ff) |-> rsp_is_locked_ff)
      else $error("caller owns an unlocked object");

   // Clearing pass never overlaps request handling.
   a_sweep_excl: assert property (@(posedge clock) disable iff (reset)
      dp_ctrl.sweep |-> (!dp_ctrl.capture && !dp_ctrl.execute))
      else $error("request handled during clearing pass");

endmodule

`default_nettype wire

>>> hdl/recursive_monitor_lock_table_top.sv
// Top level of the recursive monitor lock table.
// Joins rmlt_ctrl and rmlt_datapath; depends on rmlt_pkg.
// A request is accepted at a rising edge with start high and busy low. Its
// response is driven with rsp_strobe for the one cycle that follows the next
// edge, and must be taken at the edge that ends that cycle, the second edge
// after acceptance. Each request is handled as a registered read of the lock and
// wait memories at acceptance, then an update and write through their write
// ports in the S_EXEC state. Busy is high in S_EXEC, so no new request is
// accepted until the block is through with the last one. After reset busy stays
// high while a clearing pass zeroes both memories one entry per cycle.
`default_nettype none

module recursive_monitor_lock_table_top
   import rmlt_pkg::*;
#(
   parameter int NUM_OBJECTS = 256,
   parameter int NUM_THREADS = 16,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [CMD_W-1:0]       req_cmd,
   input  wire logic [OBJECT_W-1:0]    req_object_index,
   input  wire logic [THREAD_W-1:0]    req_thread_index,
   input  wire logic                   req_object_live,
   output logic                        rsp_strobe,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic                        rsp_is_locked,
   output logic [THREAD_W-1:0]         rsp_owner_thread,
   output logic                        rsp_caller_owns,
   output logic [DEPTH_OUT_W-1:0]      rsp_hold_depth,
   output logic                        rsp_wait_valid,
   output logic [OBJECT_W-1:0]         rsp_wait_object
);

   dp_ctrl_type dp_ctrl;
   dp_stat_type dp_stat;

   // Controller.
   rmlt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .dp_ctrl (dp_ctrl),
      .dp_stat (dp_stat)
   );

   // Datapath.
   rmlt_datapath #(
      .NUM_OBJECTS (NUM_OBJECTS),
      .NUM_THREADS (NUM_THREADS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_ctrl          (dp_ctrl),
      .dp_stat          (dp_stat),
      .req_cmd          (req_cmd),
      .req_object_index (req_object_index),
      .req_thread_index (req_thread_index),
      .req_object_live  (req_object_live),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_is_locked    (rsp_is_locked),
      .rsp_owner_thread (rsp_owner_thread),
      .rsp_caller_owns  (rsp_caller_owns),
      .rsp_hold_depth   (rsp_hold_depth),
      .rsp_wait_valid   (rsp_wait_valid),
      .rsp_wait_object  (rsp_wait_object)
   );

endmodule

`default_nettype wire
